[rtl/chse_pkg.sv]
// Package: types and constants for the chained hash set engine.
package chse_pkg;

    localparam int KEY_BYTES    = 4;
    localparam int MAX_BUCKETS  = 256;
    localparam int BUCKET_DEPTH = 4;
    localparam int SLOT_TOTAL   = MAX_BUCKETS * BUCKET_DEPTH;
    localparam int BKT_W        = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int WAY_W        = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int CNT_W        = 11;
    localparam int BC_W         = 9;
    localparam int HASH_W       = 64;
    localparam int REM_W        = BKT_W + 1;
    localparam int ROW_W        = BUCKET_DEPTH * 32;
    localparam logic [BC_W-1:0]   BC_RESET  = 9'd256;
    localparam logic [BKT_W:0]    MAX_BKT   = (BKT_W + 1)'(MAX_BUCKETS);

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_TEST   = 2'd2,
        REQ_TEST3  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_RSVD    = 2'd3
    } status_t;

    localparam logic [0:0] ADDR_BUCKET_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              was_present;
        logic [CNT_W-1:0]  key_count;
    } rsp_t;

    // Work item handed from front to back
    typedef struct packed {
        logic [1:0]       req_type;
        logic [31:0]      key;
        logic [BKT_W-1:0] bucket;
    } job_t;

    typedef enum logic [1:0] {
        FS_IDLE = 2'd0,
        FS_DIV  = 2'd1,
        FS_PUSH = 2'd2,
        FS_HASH = 2'd3
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE  = 3'd0,
        BS_READ  = 3'd1,
        BS_EXEC  = 3'd2,
        BS_OUT   = 3'd3,
        BS_CLEAR = 3'd4
    } back_state_t;

endpackage

[rtl/chse_front.sv]
// Front end: accepts requests, hashes the key and reduces it to a bucket.
module chse_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  chse_pkg::req_t       s_data,
    input  logic [chse_pkg::BC_W-1:0] bucket_count,
    output logic                 job_valid,
    input  logic                 job_ready,
    output chse_pkg::job_t       job
);
    import chse_pkg::*;

    localparam int STEP_W = $clog2(HASH_W + 1);

    front_state_t        state_reg, state_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [REM_W-1:0]    div_reg, div_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    req_t                req_reg, req_next;
    logic [REM_W:0]      trial;
    logic [BKT_W:0]      bc_sat;
    logic [7:0]          byte_v;
    logic [HASH_W-1:0]   hsum;

    always_comb begin
        if (bucket_count == '0)
            bc_sat = (BKT_W + 1)'(1);
        else if ({{(BKT_W+1 > BC_W ? BKT_W+1-BC_W : 1){1'b0}}, bucket_count} > MAX_BKT)
            bc_sat = MAX_BKT;
        else
            bc_sat = (BKT_W + 1)'(bucket_count);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        step_reg <= step_next;
        req_reg  <= req_next;
    end

    // one key byte per hash round, little-endian; bytes past the key are zero
    assign byte_v = (step_reg < STEP_W'(4)) ? req_reg.key[{step_reg[1:0], 3'b000} +: 8] : 8'd0;
    assign hsum   = hash_reg + {{(HASH_W-8){byte_v[7]}}, byte_v};

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, hash_reg[HASH_W-1]};

    always_comb begin
        state_next = state_reg;
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        req_next   = req_reg;
        s_ready    = 1'b0;
        job_valid  = 1'b0;
        unique case (state_reg)
            FS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next   = s_data;
                    hash_next  = '0;
                    rem_next   = '0;
                    div_next   = REM_W'(bc_sat);
                    step_next  = '0;
                    state_next = FS_HASH;
                end
            end
            FS_HASH: begin
                // times 31 as shift and subtract
                hash_next = (hsum << 5) - hsum;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(KEY_BYTES - 1)) begin
                    step_next  = '0;
                    state_next = FS_DIV;
                end
            end
            FS_DIV: begin
                if (trial >= {1'b0, div_reg})
                    rem_next = REM_W'(trial - {1'b0, div_reg});
                else
                    rem_next = trial[REM_W-1:0];
                hash_next = {hash_reg[HASH_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(HASH_W - 1))
                    state_next = FS_PUSH;
            end
            FS_PUSH: begin
                job_valid = 1'b1;
                if (job_ready)
                    state_next = FS_IDLE;
            end
            default: state_next = FS_IDLE;
        endcase
    end

    assign job.req_type = req_reg.req_type;
    assign job.key      = req_reg.key;
    assign job.bucket   = rem_reg[BKT_W-1:0];
endmodule

[rtl/chse_queue.sv]
// Two-entry queue between front and back.
module chse_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  chse_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output chse_pkg::job_t out_job
);
    import chse_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) mem_reg[wptr_reg] <= in_job;
    end
endmodule

[rtl/chse_back.sv]
// Back end: bucket read-modify-write, count keeping and result register.
module chse_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    output logic           job_ready,
    input  chse_pkg::job_t job,
    output logic           m_valid,
    input  logic           m_ready,
    output chse_pkg::rsp_t m_data
);
    import chse_pkg::*;

    localparam int MROW_W = ROW_W + BUCKET_DEPTH;

    // one row per bucket: {valid bits, keys}
    logic [MROW_W-1:0]       key_mem [MAX_BUCKETS];

    back_state_t             state_reg, state_next;
    job_t                    job_reg, job_next;
    logic [BKT_W-1:0]        clr_reg, clr_next;
    logic [MROW_W-1:0]       rd_reg;
    logic [ROW_W-1:0]        row_rd;
    logic [BUCKET_DEPTH-1:0] vrow_rd;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    rsp_t                    rsp_reg, rsp_next;
    logic                    wr_en;
    logic [BKT_W-1:0]        wr_addr;
    logic [ROW_W-1:0]        wr_row;
    logic [BUCKET_DEPTH-1:0] vwr_row;
    logic [BUCKET_DEPTH-1:0] hit;
    logic                    found, has_free;
    logic [WAY_W-1:0]        hit_way, free_way;

    assign row_rd  = rd_reg[ROW_W-1:0];
    assign vrow_rd = rd_reg[MROW_W-1:ROW_W];

    always_comb begin
        found = 1'b0; has_free = 1'b0; hit_way = '0; free_way = '0;
        for (int i = BUCKET_DEPTH - 1; i >= 0; i--) begin
            hit[i] = vrow_rd[i] && (row_rd[i*32 +: 32] == job_reg.key);
            if (hit[i]) begin found = 1'b1; hit_way = WAY_W'(i); end
            if (!vrow_rd[i]) begin has_free = 1'b1; free_way = WAY_W'(i); end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BS_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
        end
        job_reg <= job_next;
        rsp_reg <= rsp_next;
        if (state_reg == BS_READ)
            rd_reg <= key_mem[job_reg.bucket];
        if (wr_en) key_mem[wr_addr] <= {vwr_row, wr_row};
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        rsp_next   = rsp_reg;
        job_ready  = 1'b0;
        m_valid    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = job_reg.bucket;
        wr_row     = row_rd;
        vwr_row    = vrow_rd;
        unique case (state_reg)
            BS_CLEAR: begin
                // wipe one bucket row per cycle after reset
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_row   = '0;
                vwr_row  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BKT_W'(MAX_BUCKETS - 1))
                    state_next = BS_IDLE;
            end
            BS_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    job_next   = job;
                    state_next = BS_READ;
                end
            end
            BS_READ: state_next = BS_EXEC;
            BS_EXEC: begin
                rsp_next.status      = ST_DONE;
                rsp_next.was_present = found;
                case (job_reg.req_type)
                    REQ_ADD: begin
                        if (found) begin
                            rsp_next.status = ST_PRESENT;
                        end else if (!has_free) begin
                            rsp_next.status = ST_FULL;
                        end else begin
                            wr_en = 1'b1;
                            wr_row[free_way*32 +: 32] = job_reg.key;
                            vwr_row[free_way] = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    REQ_REMOVE: begin
                        if (found) begin
                            wr_en = 1'b1;
                            vwr_row[hit_way] = 1'b0;
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    default: ;
                endcase
                rsp_next.key_count = cnt_next;
                state_next = BS_OUT;
            end
            BS_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = BS_IDLE;
            end
            default: state_next = BS_IDLE;
        endcase
    end

    assign m_data = rsp_reg;
endmodule

[rtl/chained_hash_set_engine_core.sv]
// Top level: chained hash set engine with APB register port.
//  channel | direction | payload
//  s_      | in        | req_t  {req_type, key}
//  m_      | out       | rsp_t  {status, was_present, key_count}
//  apb     | in        | bucket_count at address 0
// Front: accept, hash (one key byte per cycle), hash modulo (one quotient bit per cycle)
// and push; it takes no new request until the push is done, which sets the rate.
// Back: take, row read, update, result per request; it takes no new job until the result
// is accepted. Reset is synchronous; the back then clears all 256 bucket rows, one
// per cycle, while the front may still accept and fill the queue.
// A stalled m_ready holds the back, the queue fills, then s_ready drops.
module chained_hash_set_engine_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  chse_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output chse_pkg::rsp_t  m_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import chse_pkg::*;

    logic [BC_W-1:0] bc_reg;
    logic            fj_valid, fj_ready, bj_valid, bj_ready;
    job_t            fj, bj;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_BUCKET_COUNT) ? {{(32-BC_W){1'b0}}, bc_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg <= BC_RESET;
        end else if (psel && penable && pwrite && paddr[2] == ADDR_BUCKET_COUNT) begin
            bc_reg <= pwdata[BC_W-1:0];
        end
    end

    chse_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .bucket_count(bc_reg),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    chse_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .in_valid(fj_valid), .in_ready(fj_ready),
        .in_job(fj), .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
    );

    chse_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job_valid(bj_valid), .job_ready(bj_ready),
        .job(bj), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
